// File: hdl/five_point_stencil_step_macros.svh
// Assertion macros for the checker file.
`ifndef FIVE_POINT_STENCIL_STEP_MACROS_SVH
`define FIVE_POINT_STENCIL_STEP_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define FPSS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fpss_pkg.sv
`default_nettype none

package fpss_pkg;

   // Field widths fixed by the block's interface
   localparam int OUT_ROW_W  = 16;
   localparam int OUT_COL_W  = 10;
   localparam int ROWS_W     = 16;
   localparam int COLS_W     = 11;
   localparam int WEIGHT_W   = 16;

   // Fixed point: Q16.16 values, Q0.16 weight, 1.0 in that format
   localparam int FRAC_BITS  = 16;
   localparam int ONE_Q      = 65536;

   // CSR port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [1:0] REG_GRID_COLS = 2'd1;
   localparam logic [1:0] REG_WEIGHT    = 2'd2;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Per-transaction bookkeeping that travels with the data.
   // Result "a" is the cell one row up, result "b" the edge copy of the cell itself.
   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic                 has_a;
      logic                 has_b;
      logic                 edge_cell;
      logic                 done;
   } meta_type;

   // Occupancy of the arithmetic stages
   typedef struct packed {
      logic a_valid;
      logic b_valid;
   } pipe_status_type;

endpackage

`default_nettype wire

// File: hdl/five_point_stencil_step.sv
`default_nettype none

// Channel   Ports                        Handshake       Contents
// req       req_cell_value               valid / stall   one grid cell, row-major
// rsp       rsp_out_row .. frame_done    valid / stall   one updated cell
// csr       psel .. prdata               APB, no waits   grid_rows, grid_cols, weight
//
// One cell is taken per clock while req_stall is low; the line buffer
// serves both reads and the write-back of a cell in that clock, so cells
// stream back to back. A result passes stage 1, stage A and stage B on its
// way to the queue; on the last row a cell can give two results.
// Reset is synchronous; the line buffers need no clearing pass.
// req_stall rises when the queue and the stages in flight fill it.
module five_point_stencil_step #(
   parameter int MAX_COLS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // cell input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0]       req_cell_value,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [fpss_pkg::OUT_ROW_W-1:0]           rsp_out_row,
   output logic [fpss_pkg::OUT_COL_W-1:0]           rsp_out_col,
   output logic signed [VALUE_WIDTH-1:0]            rsp_out_value,
   output logic                                     rsp_last_of_run,
   output logic                                     rsp_frame_done,
   // configuration
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [fpss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [fpss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fpss_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int AW = $clog2(MAX_COLS);
   localparam int EW = (AW + 1 > fpss_pkg::COLS_W) ? AW + 1 : fpss_pkg::COLS_W;
   localparam int QW = fpss_pkg::FIFO_CNT_W + 1;

   // configuration registers
   logic [fpss_pkg::ROWS_W-1:0]   grid_rows_ff, grid_rows_in;
   logic [fpss_pkg::COLS_W-1:0]   grid_cols_ff, grid_cols_in;
   logic [fpss_pkg::WEIGHT_W-1:0] weight_ff, weight_in;

   // position counters
   logic [fpss_pkg::OUT_ROW_W-1:0] row_ff, row_in;
   logic [AW-1:0]                  col_ff, col_in;

   // stage 1: line buffer data arriving
   logic                          s1_valid_ff, s1_valid_in;
   fpss_pkg::meta_type            s1_meta_ff, s1_meta_in;
   logic signed [VALUE_WIDTH-1:0] s1_cell_ff;
   logic [AW-1:0]                 s1_col_ff;
   logic signed [VALUE_WIDTH-1:0] left_ff, left_in;

   logic                          csr_write;
   logic [1:0]                    reg_idx;
   logic                          restart;
   logic [fpss_pkg::ROWS_W-1:0]   rows_m1;
   logic [EW-1:0]                 cols_ext;
   logic [EW-1:0]                 cols_m1;
   logic                          last_col;
   logic                          last_row;
   logic                          accept;
   logic [AW-1:0]                 rd_addr_b;

   logic [2*VALUE_WIDTH-1:0]      rd_data_a;
   logic [2*VALUE_WIDTH-1:0]      rd_data_b;
   logic signed [VALUE_WIDTH-1:0] centre;
   logic signed [VALUE_WIDTH-1:0] up;
   logic signed [VALUE_WIDTH-1:0] right;

   logic                          ar_valid;
   fpss_pkg::meta_type            ar_meta;
   logic signed [VALUE_WIDTH-1:0] ar_a_value;
   logic signed [VALUE_WIDTH-1:0] ar_b_value;
   fpss_pkg::pipe_status_type     ar_status;
   logic [fpss_pkg::FIFO_CNT_W-1:0] q_count;
   logic [QW-1:0]                 q_total;

   // CSR writes
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[3:2];
   assign pready    = 1'b1;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      weight_in    = weight_ff;
      restart      = 1'b0;
      if (csr_write) begin
         case (reg_idx)
            fpss_pkg::REG_GRID_ROWS: begin
               grid_rows_in = pwdata[fpss_pkg::ROWS_W-1:0];
               restart      = 1'b1;
            end
            fpss_pkg::REG_GRID_COLS: begin
               grid_cols_in = pwdata[fpss_pkg::COLS_W-1:0];
               restart      = 1'b1;
            end
            fpss_pkg::REG_WEIGHT: begin
               weight_in = pwdata[fpss_pkg::WEIGHT_W-1:0];
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // CSR reads
   always_comb begin
      case (reg_idx)
         fpss_pkg::REG_GRID_ROWS: prdata = fpss_pkg::CSR_DATA_W'(grid_rows_ff);
         fpss_pkg::REG_GRID_COLS: prdata = fpss_pkg::CSR_DATA_W'(grid_cols_ff);
         fpss_pkg::REG_WEIGHT:    prdata = fpss_pkg::CSR_DATA_W'(weight_ff);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= fpss_pkg::ROWS_W'(1);
         grid_cols_ff <= fpss_pkg::COLS_W'(1);
         weight_ff    <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         weight_ff    <= weight_in;
      end
   end

   // effective grid size: zero acts as one, columns capped at the buffer depth
   assign rows_m1  = (grid_rows_ff == '0) ? '0
                                          : fpss_pkg::ROWS_W'(grid_rows_ff - 1'b1);
   assign cols_ext = EW'(grid_cols_ff);
   always_comb begin
      if (cols_ext == '0) begin
         cols_m1 = '0;
      end else if (cols_ext > EW'(MAX_COLS)) begin
         cols_m1 = EW'(MAX_COLS - 1);
      end else begin
         cols_m1 = EW'(cols_ext - 1'b1);
      end
   end

   assign last_col = (EW'(col_ff) == cols_m1);
   assign last_row = (row_ff == rows_m1);

   // queue room covers everything already in flight
   assign q_total   = QW'(q_count) + QW'(s1_valid_ff) + QW'(ar_status.a_valid)
                    + QW'(ar_status.b_valid);
   assign req_stall = (q_total >= QW'(fpss_pkg::FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   // row/column counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : fpss_pkg::OUT_ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = AW'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line buffer: entry k and its right neighbour
   assign rd_addr_b = last_col ? col_ff : AW'(col_ff + 1'b1);

   fpss_line_mem #(
      .DEPTH  (MAX_COLS),
      .DATA_W (2 * VALUE_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (col_ff),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_col_ff),
      .wr_data   ({centre, s1_cell_ff})
   );

   // bookkeeping for the transaction entering stage 1
   always_comb begin
      s1_valid_in          = accept;
      s1_meta_in.row       = row_ff;
      s1_meta_in.col       = fpss_pkg::OUT_COL_W'(col_ff);
      s1_meta_in.has_a     = (row_ff != '0);
      s1_meta_in.has_b     = last_row;
      s1_meta_in.edge_cell = (row_ff == fpss_pkg::OUT_ROW_W'(1)) || (col_ff == '0)
                          || last_col;
      s1_meta_in.done      = last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
         s1_cell_ff <= req_cell_value;
         s1_col_ff  <= col_ff;
      end
   end

   // window: centre/up from entry k, right from entry k+1, left from last centre
   assign centre = $signed(rd_data_a[VALUE_WIDTH-1:0]);
   assign up     = $signed(rd_data_a[2*VALUE_WIDTH-1:VALUE_WIDTH]);
   assign right  = $signed(rd_data_b[VALUE_WIDTH-1:0]);
   assign left_in = s1_valid_ff ? centre : left_ff;

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   fpss_arith #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_arith (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_meta     (s1_meta_ff),
      .in_centre   (centre),
      .in_up       (up),
      .in_left     (left_ff),
      .in_right    (right),
      .in_cell     (s1_cell_ff),
      .weight      (weight_ff),
      .out_valid   (ar_valid),
      .out_meta    (ar_meta),
      .out_a_value (ar_a_value),
      .out_b_value (ar_b_value),
      .status      (ar_status)
   );

   fpss_rsp_fifo #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rsp_fifo (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (ar_valid),
      .push_meta       (ar_meta),
      .push_a_value    (ar_a_value),
      .push_b_value    (ar_b_value),
      .count           (q_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

`default_nettype wire

// File: hdl/fpss_line_mem.sv
`default_nettype none

// Two line buffers packed side by side: {row_before_previous, previous_row}.
// Two registered read ports, one write port, write-first on a collision.
module fpss_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 64
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [DATA_W-1:0]        rd_data_a,
   output logic      [DATA_W-1:0]        rd_data_b,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, bypassing a write to the same entry at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= mem_ff[rd_addr_a];
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= mem_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// File: hdl/fpss_arith.sv
`default_nettype none

// Stencil arithmetic: neighbour sum, then the two products, then floor
// shift, add and saturate (edge cells keep their centre) in front of the result queue.
module fpss_arith #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire fpss_pkg::meta_type                in_meta,
   input  wire logic signed [VALUE_WIDTH-1:0]     in_centre,
   input  wire logic signed [VALUE_WIDTH-1:0]     in_up,
   input  wire logic signed [VALUE_WIDTH-1:0]     in_left,
   input  wire logic signed [VALUE_WIDTH-1:0]     in_right,
   input  wire logic signed [VALUE_WIDTH-1:0]     in_cell,
   input  wire logic [fpss_pkg::WEIGHT_W-1:0]     weight,
   output logic                                   out_valid,
   output fpss_pkg::meta_type                     out_meta,
   output logic signed [VALUE_WIDTH-1:0]          out_a_value,
   output logic signed [VALUE_WIDTH-1:0]          out_b_value,
   output fpss_pkg::pipe_status_type              status
);

   localparam int SW = VALUE_WIDTH + 2;                          // sum of four
   localparam int WW = fpss_pkg::FRAC_BITS + 3;                  // centre weight
   localparam int PW = VALUE_WIDTH + fpss_pkg::FRAC_BITS + 3;    // products
   localparam int HW = PW - fpss_pkg::FRAC_BITS;                 // after shift
   localparam int TW = HW + 1;                                   // final sum

   // stage A: neighbour sum
   logic                          a_valid_ff, a_valid_in;
   fpss_pkg::meta_type            a_meta_ff;
   logic signed [VALUE_WIDTH-1:0] a_centre_ff;
   logic signed [VALUE_WIDTH-1:0] a_cell_ff;
   logic signed [SW-1:0]          a_sum_ff, a_sum_in;

   // stage B: products
   logic                          b_valid_ff, b_valid_in;
   fpss_pkg::meta_type            b_meta_ff;
   logic signed [VALUE_WIDTH-1:0] b_centre_ff;
   logic signed [VALUE_WIDTH-1:0] b_cell_ff;
   logic signed [PW-1:0]          b_pc_ff, b_pc_in;
   logic signed [PW-1:0]          b_pn_ff, b_pn_in;

   logic signed [WW-1:0]                  centre_w;
   logic signed [fpss_pkg::WEIGHT_W:0]    c_s;
   logic signed [HW-1:0]                  pc_sh;
   logic signed [HW-1:0]                  pn_sh;
   logic signed [TW-1:0]                  total;
   logic                                  sat_hi;
   logic                                  sat_lo;
   logic signed [VALUE_WIDTH-1:0]         mix_value;

   // w = 1.0 - 4c, c = weight
   assign centre_w = $signed(WW'(fpss_pkg::ONE_Q) - WW'({weight, 2'b00}));
   assign c_s      = $signed({1'b0, weight});

   assign a_valid_in = in_valid;
   assign a_sum_in   = SW'(in_up) + SW'(in_cell) + SW'(in_left) + SW'(in_right);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_meta_ff   <= in_meta;
      a_centre_ff <= in_centre;
      a_cell_ff   <= in_cell;
      a_sum_ff    <= a_sum_in;
   end

   // products, registered before the add
   assign b_valid_in = a_valid_ff;
   assign b_pc_in    = a_centre_ff * centre_w;
   assign b_pn_in    = a_sum_ff * c_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_meta_ff   <= a_meta_ff;
      b_centre_ff <= a_centre_ff;
      b_cell_ff   <= a_cell_ff;
      b_pc_ff     <= b_pc_in;
      b_pn_ff     <= b_pn_in;
   end

   // floor shift: drop the fraction bits of each product
   assign pc_sh = $signed(b_pc_ff[PW-1:fpss_pkg::FRAC_BITS]);
   assign pn_sh = $signed(b_pn_ff[PW-1:fpss_pkg::FRAC_BITS]);
   assign total = TW'(pc_sh) + TW'(pn_sh);

   // saturate to the value range
   assign sat_hi = !total[TW-1] && (|total[TW-2:VALUE_WIDTH-1]);
   assign sat_lo = total[TW-1] && !(&total[TW-2:VALUE_WIDTH-1]);

   always_comb begin
      if (b_meta_ff.edge_cell) begin
         mix_value = b_centre_ff;
      end else if (sat_hi) begin
         mix_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else if (sat_lo) begin
         mix_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         mix_value = total[VALUE_WIDTH-1:0];
      end
   end

   assign out_valid      = b_valid_ff;
   assign out_meta       = b_meta_ff;
   assign out_a_value    = mix_value;
   assign out_b_value    = b_cell_ff;
   assign status.a_valid = a_valid_ff;
   assign status.b_valid = b_valid_ff;

endmodule

`default_nettype wire

// File: hdl/fpss_rsp_fifo.sv
`default_nettype none

// Result queue. One entry per input transaction with a result, holding up to two results;
// the head is shown as result a first, then result b.
module fpss_rsp_fifo #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push_valid,
   input  wire fpss_pkg::meta_type                 push_meta,
   input  wire logic signed [VALUE_WIDTH-1:0]      push_a_value,
   input  wire logic signed [VALUE_WIDTH-1:0]      push_b_value,
   output logic [fpss_pkg::FIFO_CNT_W-1:0]         count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [fpss_pkg::OUT_ROW_W-1:0]          rsp_out_row,
   output logic [fpss_pkg::OUT_COL_W-1:0]          rsp_out_col,
   output logic signed [VALUE_WIDTH-1:0]           rsp_out_value,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_frame_done
);

   localparam int PTR_W = $clog2(fpss_pkg::FIFO_DEPTH);

   fpss_pkg::meta_type            meta_ff  [fpss_pkg::FIFO_DEPTH];
   logic signed [VALUE_WIDTH-1:0] aval_ff  [fpss_pkg::FIFO_DEPTH];
   logic signed [VALUE_WIDTH-1:0] bval_ff  [fpss_pkg::FIFO_DEPTH];

   logic [PTR_W-1:0]                wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [fpss_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            half_ff, half_in;

   fpss_pkg::meta_type head;
   logic               push;
   logic               take;
   logic               show_b;
   logic               pop;

   // entries that carry no result are dropped
   assign push = push_valid && (push_meta.has_a || push_meta.has_b);

   assign head   = meta_ff[rd_ptr_ff];
   assign show_b = !head.has_a || half_ff;
   assign take   = rsp_valid && !rsp_stall;
   assign pop    = take && (show_b || !head.has_b);

   always_ff @(posedge clock) begin
      if (push) begin
         meta_ff[wr_ptr_ff] <= push_meta;
         aval_ff[wr_ptr_ff] <= push_a_value;
         bval_ff[wr_ptr_ff] <= push_b_value;
      end
   end

   // pointers, fill count and half-served flag
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = fpss_pkg::FIFO_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = fpss_pkg::FIFO_CNT_W'(count_ff - 1'b1);
      end
      half_in = half_ff;
      if (pop) begin
         half_in = 1'b0;
      end else if (take) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

   // output view of the head entry
   assign count           = count_ff;
   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_row     = show_b ? head.row
                                   : fpss_pkg::OUT_ROW_W'(head.row - 1'b1);
   assign rsp_out_col     = head.col;
   assign rsp_out_value   = show_b ? bval_ff[rd_ptr_ff] : aval_ff[rd_ptr_ff];
   assign rsp_last_of_run = show_b || !head.has_b;
   assign rsp_frame_done  = show_b && head.done;

endmodule

`default_nettype wire

// File: hdl/fpss_checker.sv
`default_nettype none

`include "five_point_stencil_step_macros.svh"

// Port-level checks on the result channel.
module fpss_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_last_of_run,
   input wire logic rsp_frame_done
);

   // a stalled transaction stays offered
   `FPSS_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")

   // the queue comes out of reset empty
   `FPSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered right after reset")

   // a run that is not finished continues at once with its second result
   `FPSS_ASSERT_CLK(a_run_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid, "second result of a run missing")

   // the frame ends on the last result of a run
   `FPSS_ASSERT_CLK(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done |-> rsp_last_of_run, "frame_done without last_of_run")

endmodule

bind five_point_stencil_step fpss_checker u_fpss_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_done  (rsp_frame_done)
);

`default_nettype wire
